@@ rtl/stu_pkg.sv @@
// Shared constants, opcodes and types for the seconds/microseconds arithmetic unit.
`timescale 1ns / 1ps
`default_nettype none

package stu_pkg;

  localparam int SEC_WIDTH_DEF = 40;
  localparam int OP_W          = 4;
  localparam int USEC_W        = 21;
  localparam int UNORM_W       = 22;  // microseconds before normalization
  localparam int USEC_MAG_W    = 20;  // magnitude below one second
  localparam int MS_W          = 50;
  localparam int ORDER_W       = 2;
  localparam int NUM_STAGES    = 8;

  localparam logic [OP_W-1:0] OP_ADD      = 4'd0;
  localparam logic [OP_W-1:0] OP_SUB      = 4'd1;
  localparam logic [OP_W-1:0] OP_INC      = 4'd2;
  localparam logic [OP_W-1:0] OP_DEC      = 4'd3;
  localparam logic [OP_W-1:0] OP_CMP      = 4'd4;
  localparam logic [OP_W-1:0] OP_TO_MS    = 4'd5;
  localparam logic [OP_W-1:0] OP_FROM_MS  = 4'd6;
  localparam logic [OP_W-1:0] OP_ADD_SECS = 4'd7;
  localparam logic [OP_W-1:0] OP_SUB_SECS = 4'd8;

  localparam logic [ORDER_W-1:0] ORDER_LESS    = 2'd0;
  localparam logic [ORDER_W-1:0] ORDER_EQUAL   = 2'd1;
  localparam logic [ORDER_W-1:0] ORDER_GREATER = 2'd2;

  localparam int USEC_PER_SEC = 1000000;
  localparam int MS_FACTOR    = 1000;

  // Microseconds divided by 1000 through a reciprocal: exact below 2^21.
  localparam int AU_MAG_W  = 21;
  localparam int AU_K_W    = 22;
  localparam int AU_SHIFT  = 31;
  localparam int AU_Q_W    = 11;
  localparam int AU_PROD_W = AU_SHIFT + AU_Q_W;
  localparam logic [AU_K_W-1:0] AU_K = 22'd2147484;

  // One long-division digit by 1000 through a reciprocal: exact below 2^26.
  localparam int DIV_Q_W    = 16;
  localparam int DIV_R_W    = 10;
  localparam int DIV_X_W    = DIV_R_W + DIV_Q_W;
  localparam int DIV_K_W    = 27;
  localparam int DIV_SHIFT  = 36;
  localparam int DIV_PROD_W = DIV_SHIFT + DIV_Q_W;
  localparam logic [DIV_K_W-1:0] DIV_K = 27'd68719477;
  localparam int MS_TOP_W   = MS_W - 2 * DIV_Q_W;
  localparam int QALL_W     = 3 * DIV_Q_W;

  typedef logic [OP_W-1:0] op_t;

  // Load enables of the two register stages that a unit spans.
  typedef struct packed {
    logic first;
    logic second;
  } stage_en_t;

endpackage

`default_nettype wire

@@ rtl/sec_usec_time_arith_unit.sv @@
// Top level of the seconds/microseconds timestamp arithmetic unit.
// Operations arrive on the s_axis channel: tuser carries the opcode and tdata the two
// time values and the millisecond count. Every transaction in produces exactly one
// transaction out on m_axis, whose tdata holds the result seconds and microseconds,
// the millisecond conversion and the compare order; fields that an opcode does not
// produce are zero, and unknown opcodes give an all-zero result.
// The unit is an eight-stage pipeline that sustains one transaction per cycle while
// m_axis_tready stays high. The depth is set by the millisecond-to-seconds conversion,
// which runs three long-division digits by 1000, each a reciprocal multiply stage
// followed by a remainder stage. A valid bit travels with each stage and every stage
// reloads once its successor frees up, so bubbles are squeezed out and a stall on
// m_axis_tready loses or repeats nothing; s_axis_tready stays high while any stage is
// empty. The last stage is the output register. Synchronous reset clears only the
// valid bits; the data registers are not reset.
`timescale 1ns / 1ps
`default_nettype none

module sec_usec_time_arith_unit #(
  parameter int SEC_WIDTH = stu_pkg::SEC_WIDTH_DEF,
  localparam int IN_BITS  = 2 * SEC_WIDTH + 2 * stu_pkg::USEC_W + stu_pkg::MS_W,
  localparam int IN_W     = ((IN_BITS + 7) / 8) * 8,
  localparam int OUT_BITS = SEC_WIDTH + stu_pkg::USEC_W + stu_pkg::MS_W + stu_pkg::ORDER_W,
  localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  // a_sec, a_usec, b_sec, b_usec, milliseconds
  input  logic [IN_W-1:0]           s_axis_tdata,
  // opcode
  input  logic [stu_pkg::OP_W-1:0]  s_axis_tuser,
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  // r_sec, r_usec, msec_out, order
  output logic [OUT_W-1:0]          m_axis_tdata
);

  localparam int N          = stu_pkg::NUM_STAGES;
  localparam int A_USEC_LSB = SEC_WIDTH;
  localparam int B_SEC_LSB  = A_USEC_LSB + stu_pkg::USEC_W;
  localparam int B_USEC_LSB = B_SEC_LSB + SEC_WIDTH;
  localparam int MS_LSB     = B_USEC_LSB + stu_pkg::USEC_W;
  localparam int LO_W       = 2 * stu_pkg::DIV_Q_W;

  // Stage handshake.
  logic [N:1]   vld;
  logic [N:0]   vin;
  logic [N+1:1] rdy;

  assign vin      = {vld, s_axis_tvalid};
  assign rdy[N+1] = m_axis_tready;

  for (genvar k = 1; k <= N; k++) begin : g_stage
    assign rdy[k] = !vld[k] || rdy[k+1];
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (rdy[k]) begin
        vld[k] <= vin[k-1];
      end
    end
  end

  assign s_axis_tready = rdy[1];
  assign m_axis_tvalid = vld[N];

  // Stage 1.
  stu_pkg::op_t                       op1;
  logic signed [SEC_WIDTH-1:0]        sec1;
  logic signed [stu_pkg::UNORM_W-1:0] usec_raw1;
  logic [stu_pkg::ORDER_W-1:0]        order1;
  logic [stu_pkg::MS_W-1:0]           a_ms1;
  logic [stu_pkg::AU_MAG_W-1:0]       au_mag1;
  logic                               au_neg1;
  logic [stu_pkg::MS_W-1:0]           ms_mag1;
  logic                               ms_neg1;

  stu_front #(
    .SEC_WIDTH (SEC_WIDTH)
  ) u_front (
    .clk          (clk),
    .en           (rdy[1]),
    .opcode       (s_axis_tuser),
    .a_sec        (signed'(s_axis_tdata[SEC_WIDTH-1:0])),
    .a_usec       (signed'(s_axis_tdata[A_USEC_LSB +: stu_pkg::USEC_W])),
    .b_sec        (signed'(s_axis_tdata[B_SEC_LSB +: SEC_WIDTH])),
    .b_usec       (signed'(s_axis_tdata[B_USEC_LSB +: stu_pkg::USEC_W])),
    .milliseconds (signed'(s_axis_tdata[MS_LSB +: stu_pkg::MS_W])),
    .op           (op1),
    .sec          (sec1),
    .usec_raw     (usec_raw1),
    .order        (order1),
    .a_ms         (a_ms1),
    .au_mag       (au_mag1),
    .au_neg       (au_neg1),
    .ms_mag       (ms_mag1),
    .ms_neg       (ms_neg1)
  );

  // Stages 2 and 3: normalization and to-milliseconds.
  stu_pkg::stage_en_t                norm_en;
  stu_pkg::op_t                      op3;
  logic signed [SEC_WIDTH-1:0]       sec3;
  logic signed [stu_pkg::USEC_W-1:0] usec3;
  logic [stu_pkg::MS_W-1:0]          msec3;

  assign norm_en = '{first: rdy[2], second: rdy[3]};

  stu_norm #(
    .SEC_WIDTH (SEC_WIDTH)
  ) u_norm (
    .clk     (clk),
    .en      (norm_en),
    .op_in   (op1),
    .sec_in  (sec1),
    .usec_in (usec_raw1),
    .a_ms    (a_ms1),
    .au_mag  (au_mag1),
    .au_neg  (au_neg1),
    .op      (op3),
    .sec     (sec3),
    .usec    (usec3),
    .msec    (msec3)
  );

  // Stages 2 to 7: milliseconds divided by 1000, one 16-bit digit per two stages.
  stu_pkg::stage_en_t             div_en0;
  stu_pkg::stage_en_t             div_en1;
  stu_pkg::stage_en_t             div_en2;
  logic [stu_pkg::DIV_X_W-1:0]    x0;
  logic [stu_pkg::DIV_X_W-1:0]    x1;
  logic [stu_pkg::DIV_X_W-1:0]    x2;
  logic [stu_pkg::DIV_Q_W-1:0]    q0;
  logic [stu_pkg::DIV_Q_W-1:0]    q1;
  logic [stu_pkg::DIV_Q_W-1:0]    q2;
  logic [stu_pkg::DIV_R_W-1:0]    r0;
  logic [stu_pkg::DIV_R_W-1:0]    r1;
  logic [stu_pkg::DIV_R_W-1:0]    r2;

  logic [LO_W-1:0]                ms_lo_d  [2:3];
  logic [stu_pkg::DIV_Q_W-1:0]    chunk2_d [4:5];

  assign div_en0 = '{first: rdy[2], second: rdy[3]};
  assign div_en1 = '{first: rdy[4], second: rdy[5]};
  assign div_en2 = '{first: rdy[6], second: rdy[7]};

  assign x0 = stu_pkg::DIV_X_W'(ms_mag1[stu_pkg::MS_W-1 -: stu_pkg::MS_TOP_W]);
  assign x1 = {r0, ms_lo_d[3][LO_W-1 -: stu_pkg::DIV_Q_W]};
  assign x2 = {r1, chunk2_d[5]};

  stu_div1k_step u_div0 (.clk(clk), .en(div_en0), .x(x0), .q(q0), .r(r0));
  stu_div1k_step u_div1 (.clk(clk), .en(div_en1), .x(x1), .q(q1), .r(r1));
  stu_div1k_step u_div2 (.clk(clk), .en(div_en2), .x(x2), .q(q2), .r(r2));

  // Values that ride along until the output stage.
  logic [stu_pkg::ORDER_W-1:0]       order_d  [2:7];
  logic                              ms_neg_d [2:7];
  stu_pkg::op_t                      op_d     [4:7];
  logic signed [SEC_WIDTH-1:0]       sec_d    [4:7];
  logic signed [stu_pkg::USEC_W-1:0] usec_d   [4:7];
  logic [stu_pkg::MS_W-1:0]          msec_d   [4:7];
  logic [stu_pkg::DIV_Q_W-1:0]       q0_d     [4:7];
  logic [stu_pkg::DIV_Q_W-1:0]       q1_d     [6:7];

  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      order_d[2]  <= order1;
      ms_neg_d[2] <= ms_neg1;
      ms_lo_d[2]  <= ms_mag1[LO_W-1:0];
    end
    if (rdy[3]) begin
      order_d[3]  <= order_d[2];
      ms_neg_d[3] <= ms_neg_d[2];
      ms_lo_d[3]  <= ms_lo_d[2];
    end
    if (rdy[4]) begin
      order_d[4]  <= order_d[3];
      ms_neg_d[4] <= ms_neg_d[3];
      chunk2_d[4] <= ms_lo_d[3][stu_pkg::DIV_Q_W-1:0];
      op_d[4]     <= op3;
      sec_d[4]    <= sec3;
      usec_d[4]   <= usec3;
      msec_d[4]   <= msec3;
      q0_d[4]     <= q0;
    end
    if (rdy[5]) begin
      order_d[5]  <= order_d[4];
      ms_neg_d[5] <= ms_neg_d[4];
      chunk2_d[5] <= chunk2_d[4];
      op_d[5]     <= op_d[4];
      sec_d[5]    <= sec_d[4];
      usec_d[5]   <= usec_d[4];
      msec_d[5]   <= msec_d[4];
      q0_d[5]     <= q0_d[4];
    end
    if (rdy[6]) begin
      order_d[6]  <= order_d[5];
      ms_neg_d[6] <= ms_neg_d[5];
      op_d[6]     <= op_d[5];
      sec_d[6]    <= sec_d[5];
      usec_d[6]   <= usec_d[5];
      msec_d[6]   <= msec_d[5];
      q0_d[6]     <= q0_d[5];
      q1_d[6]     <= q1;
    end
    if (rdy[7]) begin
      order_d[7]  <= order_d[6];
      ms_neg_d[7] <= ms_neg_d[6];
      op_d[7]     <= op_d[6];
      sec_d[7]    <= sec_d[6];
      usec_d[7]   <= usec_d[6];
      msec_d[7]   <= msec_d[6];
      q0_d[7]     <= q0_d[6];
      q1_d[7]     <= q1_d[6];
    end
  end

  // Stage 8: sign the conversion from milliseconds and select the result fields.
  logic [stu_pkg::QALL_W-1:0]          q_all;
  logic signed [stu_pkg::QALL_W:0]     from_sec;
  logic signed [stu_pkg::USEC_W-1:0]   from_usec;
  logic signed [SEC_WIDTH-1:0]         r_sec_next;
  logic signed [stu_pkg::USEC_W-1:0]   r_usec_next;
  logic [stu_pkg::MS_W-1:0]            msec_next;
  logic [stu_pkg::ORDER_W-1:0]         order_next;

  logic signed [SEC_WIDTH-1:0]         r_sec;
  logic signed [stu_pkg::USEC_W-1:0]   r_usec;
  logic [stu_pkg::MS_W-1:0]            msec_out;
  logic [stu_pkg::ORDER_W-1:0]         order;

  always_comb begin
    q_all     = {q0_d[7], q1_d[7], q2};
    from_sec  = signed'({1'b0, q_all});
    from_usec = signed'(stu_pkg::USEC_W'(stu_pkg::USEC_MAG_W'(r2 * stu_pkg::MS_FACTOR)));
    if (ms_neg_d[7]) begin
      from_sec  = -from_sec;
      from_usec = -from_usec;
    end

    r_sec_next  = '0;
    r_usec_next = '0;
    msec_next   = '0;
    order_next  = '0;
    unique case (op_d[7]) inside
      stu_pkg::OP_ADD, stu_pkg::OP_SUB, stu_pkg::OP_INC, stu_pkg::OP_DEC,
      stu_pkg::OP_ADD_SECS, stu_pkg::OP_SUB_SECS: begin
        r_sec_next  = sec_d[7];
        r_usec_next = usec_d[7];
      end
      stu_pkg::OP_CMP:    order_next = order_d[7];
      stu_pkg::OP_TO_MS:  msec_next  = msec_d[7];
      stu_pkg::OP_FROM_MS: begin
        r_sec_next  = SEC_WIDTH'(from_sec);
        r_usec_next = from_usec;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rdy[N]) begin
      r_sec    <= r_sec_next;
      r_usec   <= r_usec_next;
      msec_out <= msec_next;
      order    <= order_next;
    end
  end

  assign m_axis_tdata = OUT_W'({order, msec_out, r_usec, r_sec});

endmodule

`default_nettype wire

@@ rtl/stu_front.sv @@
// First pipeline stage: operand decode, add/subtract, compare and magnitudes.
`timescale 1ns / 1ps
`default_nettype none

module stu_front #(
  parameter int SEC_WIDTH = stu_pkg::SEC_WIDTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 en,
  input  stu_pkg::op_t                         opcode,
  input  logic signed [SEC_WIDTH-1:0]          a_sec,
  input  logic signed [stu_pkg::USEC_W-1:0]    a_usec,
  input  logic signed [SEC_WIDTH-1:0]          b_sec,
  input  logic signed [stu_pkg::USEC_W-1:0]    b_usec,
  input  logic signed [stu_pkg::MS_W-1:0]      milliseconds,
  output stu_pkg::op_t                         op,
  output logic signed [SEC_WIDTH-1:0]          sec,
  output logic signed [stu_pkg::UNORM_W-1:0]   usec_raw,
  output logic [stu_pkg::ORDER_W-1:0]          order,
  output logic [stu_pkg::MS_W-1:0]             a_ms,
  output logic [stu_pkg::AU_MAG_W-1:0]         au_mag,
  output logic                                 au_neg,
  output logic [stu_pkg::MS_W-1:0]             ms_mag,
  output logic                                 ms_neg
);

  logic signed [SEC_WIDTH-1:0]        sec_sum;
  logic signed [SEC_WIDTH-1:0]        sec_diff;
  logic signed [stu_pkg::UNORM_W-1:0] au_x;
  logic signed [stu_pkg::UNORM_W-1:0] bu_x;
  logic signed [stu_pkg::MS_W-1:0]    as_ms;
  logic signed [SEC_WIDTH-1:0]        sec_next;
  logic signed [stu_pkg::UNORM_W-1:0] usec_next;
  logic [stu_pkg::ORDER_W-1:0]        order_next;

  assign sec_sum  = a_sec + b_sec;
  assign sec_diff = a_sec - b_sec;
  assign au_x     = stu_pkg::UNORM_W'(a_usec);
  assign bu_x     = stu_pkg::UNORM_W'(b_usec);
  assign as_ms    = stu_pkg::MS_W'(a_sec);

  always_comb begin
    sec_next  = a_sec;
    usec_next = au_x;
    unique case (opcode)
      stu_pkg::OP_ADD: begin
        sec_next  = sec_sum;
        usec_next = au_x + bu_x;
      end
      stu_pkg::OP_SUB: begin
        sec_next  = sec_diff;
        usec_next = au_x - bu_x;
      end
      stu_pkg::OP_INC:      usec_next = au_x + stu_pkg::UNORM_W'(1);
      stu_pkg::OP_DEC:      usec_next = au_x - stu_pkg::UNORM_W'(1);
      stu_pkg::OP_ADD_SECS: sec_next  = sec_sum;
      stu_pkg::OP_SUB_SECS: sec_next  = sec_diff;
      default: ;
    endcase
  end

  always_comb begin
    if (a_sec > b_sec || (a_sec == b_sec && a_usec > b_usec)) begin
      order_next = stu_pkg::ORDER_GREATER;
    end else if (a_sec == b_sec && a_usec == b_usec) begin
      order_next = stu_pkg::ORDER_EQUAL;
    end else begin
      order_next = stu_pkg::ORDER_LESS;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      op       <= opcode;
      sec      <= sec_next;
      usec_raw <= usec_next;
      order    <= order_next;
      // Multiply by 1000 as 1024 - 32 + 8, wrapping at the millisecond width.
      a_ms     <= unsigned'((as_ms <<< 10) - (as_ms <<< 5) + (as_ms <<< 3));
      au_mag   <= a_usec[stu_pkg::USEC_W-1] ? unsigned'(-a_usec) : unsigned'(a_usec);
      au_neg   <= a_usec[stu_pkg::USEC_W-1];
      ms_mag   <= milliseconds[stu_pkg::MS_W-1] ? unsigned'(-milliseconds)
                                                : unsigned'(milliseconds);
      ms_neg   <= milliseconds[stu_pkg::MS_W-1];
    end
  end

endmodule

`default_nettype wire

@@ rtl/stu_norm.sv @@
// Two pipeline stages: microsecond carry and sign fix-up, plus the to-milliseconds sum.
`timescale 1ns / 1ps
`default_nettype none

module stu_norm #(
  parameter int SEC_WIDTH = stu_pkg::SEC_WIDTH_DEF
) (
  input  logic                                 clk,
  input  stu_pkg::stage_en_t                   en,
  input  stu_pkg::op_t                         op_in,
  input  logic signed [SEC_WIDTH-1:0]          sec_in,
  input  logic signed [stu_pkg::UNORM_W-1:0]   usec_in,
  input  logic [stu_pkg::MS_W-1:0]             a_ms,
  input  logic [stu_pkg::AU_MAG_W-1:0]         au_mag,
  input  logic                                 au_neg,
  output stu_pkg::op_t                         op,
  output logic signed [SEC_WIDTH-1:0]          sec,
  output logic signed [stu_pkg::USEC_W-1:0]    usec,
  output logic [stu_pkg::MS_W-1:0]             msec
);

  logic                               is_norm;
  logic                               u_neg;
  logic [stu_pkg::UNORM_W-1:0]        u_mag;
  logic [stu_pkg::UNORM_W-1:0]        u_rem_w;
  logic [1:0]                         carry;
  logic signed [SEC_WIDTH-1:0]        carry_s;
  logic signed [SEC_WIDTH-1:0]        sec_carried;
  logic signed [stu_pkg::USEC_W-1:0]  usec_carried;

  stu_pkg::op_t                       op_mid;
  logic                               norm_mid;
  logic signed [SEC_WIDTH-1:0]        sec_mid;
  logic signed [stu_pkg::USEC_W-1:0]  usec_mid;
  logic [stu_pkg::MS_W-1:0]           a_ms_mid;
  logic [stu_pkg::AU_PROD_W-1:0]      prod_au;
  logic                               au_neg_mid;

  logic [stu_pkg::AU_Q_W-1:0]         au_q;
  logic [stu_pkg::MS_W-1:0]           au_frac;
  logic signed [SEC_WIDTH-1:0]        sec_fix;
  logic signed [stu_pkg::USEC_W-1:0]  usec_fix;

  // Carry whole seconds out of the microseconds, truncating toward zero.
  always_comb begin
    is_norm = op_in == stu_pkg::OP_ADD || op_in == stu_pkg::OP_SUB ||
              op_in == stu_pkg::OP_INC || op_in == stu_pkg::OP_DEC;
    u_neg   = usec_in[stu_pkg::UNORM_W-1];
    u_mag   = u_neg ? unsigned'(-usec_in) : unsigned'(usec_in);
    if (u_mag >= stu_pkg::UNORM_W'(2 * stu_pkg::USEC_PER_SEC)) begin
      carry   = 2'd2;
      u_rem_w = u_mag - stu_pkg::UNORM_W'(2 * stu_pkg::USEC_PER_SEC);
    end else if (u_mag >= stu_pkg::UNORM_W'(stu_pkg::USEC_PER_SEC)) begin
      carry   = 2'd1;
      u_rem_w = u_mag - stu_pkg::UNORM_W'(stu_pkg::USEC_PER_SEC);
    end else begin
      carry   = 2'd0;
      u_rem_w = u_mag;
    end
    carry_s      = signed'(SEC_WIDTH'(carry));
    sec_carried  = u_neg ? sec_in - carry_s : sec_in + carry_s;
    usec_carried = signed'(stu_pkg::USEC_W'(u_rem_w[stu_pkg::USEC_MAG_W-1:0]));
    if (u_neg) begin
      usec_carried = -usec_carried;
    end
  end

  always_ff @(posedge clk) begin
    if (en.first) begin
      op_mid     <= op_in;
      norm_mid   <= is_norm;
      sec_mid    <= is_norm ? sec_carried : sec_in;
      usec_mid   <= is_norm ? usec_carried : usec_in[stu_pkg::USEC_W-1:0];
      a_ms_mid   <= a_ms;
      prod_au    <= au_mag * stu_pkg::AU_K;
      au_neg_mid <= au_neg;
    end
  end

  // Give the microseconds the sign of the seconds by borrowing one second.
  always_comb begin
    au_q     = prod_au[stu_pkg::AU_SHIFT +: stu_pkg::AU_Q_W];
    au_frac  = au_neg_mid ? -stu_pkg::MS_W'(au_q) : stu_pkg::MS_W'(au_q);
    sec_fix  = sec_mid;
    usec_fix = usec_mid;
    if (norm_mid && sec_mid > 0 && usec_mid < 0) begin
      sec_fix  = sec_mid - SEC_WIDTH'(1);
      usec_fix = usec_mid + stu_pkg::USEC_W'(stu_pkg::USEC_PER_SEC);
    end else if (norm_mid && sec_mid < 0 && usec_mid > 0) begin
      sec_fix  = sec_mid + SEC_WIDTH'(1);
      usec_fix = usec_mid - stu_pkg::USEC_W'(stu_pkg::USEC_PER_SEC);
    end
  end

  always_ff @(posedge clk) begin
    if (en.second) begin
      op   <= op_mid;
      sec  <= sec_fix;
      usec <= usec_fix;
      msec <= a_ms_mid + au_frac;
    end
  end

endmodule

`default_nettype wire

@@ rtl/stu_div1k_step.sv @@
// One pipelined long-division digit by 1000: reciprocal multiply, then quotient and remainder.
`timescale 1ns / 1ps
`default_nettype none

module stu_div1k_step (
  input  logic                            clk,
  input  stu_pkg::stage_en_t              en,
  input  logic [stu_pkg::DIV_X_W-1:0]     x,
  output logic [stu_pkg::DIV_Q_W-1:0]     q,
  output logic [stu_pkg::DIV_R_W-1:0]     r
);

  logic [stu_pkg::DIV_PROD_W-1:0] prod;
  logic [stu_pkg::DIV_X_W-1:0]    x_d;
  logic [stu_pkg::DIV_Q_W-1:0]    q_c;
  logic [stu_pkg::DIV_X_W-1:0]    r_w;

  // The dividend stays below 1000 * 2^16, so the product fits and the digit is exact.
  assign q_c = prod[stu_pkg::DIV_SHIFT +: stu_pkg::DIV_Q_W];
  assign r_w = x_d - stu_pkg::DIV_X_W'(q_c * stu_pkg::MS_FACTOR);

  always_ff @(posedge clk) begin
    if (en.first) begin
      prod <= x * stu_pkg::DIV_K;
      x_d  <= x;
    end
    if (en.second) begin
      q <= q_c;
      r <= r_w[stu_pkg::DIV_R_W-1:0];
    end
  end

endmodule

`default_nettype wire

@@ tb/sv/stu_result_checker.sv @@
// Checker for the timestamp arithmetic unit: predicts each result and compares it with the output stream.
`timescale 1ns / 1ps

module stu_result_checker #(
  parameter int IN_W  = 176,
  parameter int OUT_W = 120
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_axis_tvalid,
  input  logic              s_axis_tready,
  // a_sec, a_usec, b_sec, b_usec, milliseconds
  input  logic [IN_W-1:0]   s_axis_tdata,
  // opcode
  input  stu_pkg::op_t      s_axis_tuser,
  input  logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  // r_sec, r_usec, msec_out, order
  input  logic [OUT_W-1:0]  m_axis_tdata,
  output int                mismatch_count,
  output int                pending_results
);

  import stu_pkg::*;

  localparam int SEC_W    = SEC_WIDTH_DEF;
  localparam int OUT_BITS = SEC_W + USEC_W + MS_W + ORDER_W;

  // Input field offsets inside s_axis_tdata.
  localparam int AS_LO = 0;
  localparam int AU_LO = SEC_W;
  localparam int BS_LO = SEC_W + USEC_W;
  localparam int BU_LO = 2 * SEC_W + USEC_W;
  localparam int MS_LO = 2 * SEC_W + 2 * USEC_W;

  // Declared from the top bit down, so r_sec lands in the lowest bits.
  typedef struct packed {
    logic [ORDER_W-1:0] order;
    logic [MS_W-1:0]    msec;
    logic [USEC_W-1:0]  usec;
    logic [SEC_W-1:0]   sec;
  } time_result_t;

  typedef struct packed {
    longint sec;
    longint usec;
  } time_value_t;

  time_result_t expected_results[$];
  time_result_t got_result;
  time_result_t want_result;
  int           result_index = 0;

  initial begin
    mismatch_count  = 0;
    pending_results = 0;
  end

  function automatic longint wrap_seconds(longint v);
    logic [SEC_W-1:0] t;
    t = v[SEC_W-1:0];
    return longint'($signed(t));
  endfunction

  // Carries whole seconds out of the microseconds, then gives the
  // microseconds the sign of the seconds with one borrow or carry.
  function automatic time_value_t normalize_time(longint s, longint u);
    time_value_t t;
    s = wrap_seconds(s + u / USEC_PER_SEC);
    u = u % USEC_PER_SEC;
    if (s >= 1 && u < 0) begin
      s = wrap_seconds(s - 1);
      u = u + USEC_PER_SEC;
    end else if (s < 0 && u > 0) begin
      s = wrap_seconds(s + 1);
      u = u - USEC_PER_SEC;
    end
    t.sec  = s;
    t.usec = u;
    return t;
  endfunction

  function automatic time_result_t predict_time_result(op_t op, logic [IN_W-1:0] d);
    time_result_t r;
    time_value_t  t;
    longint       as, au, bs, bu, ms, s, u, q, m;
    as = longint'($signed(d[AS_LO +: SEC_W]));
    au = longint'($signed(d[AU_LO +: USEC_W]));
    bs = longint'($signed(d[BS_LO +: SEC_W]));
    bu = longint'($signed(d[BU_LO +: USEC_W]));
    ms = longint'($signed(d[MS_LO +: MS_W]));
    r = '0;
    s = 0;
    u = 0;
    case (op)
      OP_ADD: begin
        t = normalize_time(wrap_seconds(as + bs), au + bu);
        s = t.sec;
        u = t.usec;
      end
      OP_SUB: begin
        t = normalize_time(wrap_seconds(as - bs), au - bu);
        s = t.sec;
        u = t.usec;
      end
      OP_INC: begin
        t = normalize_time(as, au + 1);
        s = t.sec;
        u = t.usec;
      end
      OP_DEC: begin
        t = normalize_time(as, au - 1);
        s = t.sec;
        u = t.usec;
      end
      OP_CMP: begin
        if (as > bs || (as == bs && au > bu)) r.order = ORDER_GREATER;
        else if (as == bs && au == bu) r.order = ORDER_EQUAL;
        else r.order = ORDER_LESS;
      end
      OP_TO_MS: begin
        m = as * MS_FACTOR + au / MS_FACTOR;
        r.msec = m[MS_W-1:0];
      end
      OP_FROM_MS: begin
        q = ms / MS_FACTOR;
        s = wrap_seconds(q);
        u = (ms - q * MS_FACTOR) * MS_FACTOR;
      end
      OP_ADD_SECS: begin
        s = wrap_seconds(as + bs);
        u = au;
      end
      OP_SUB_SECS: begin
        s = wrap_seconds(as - bs);
        u = au;
      end
      default: begin
      end
    endcase
    r.sec  = s[SEC_W-1:0];
    r.usec = u[USEC_W-1:0];
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got_v,
                                 input logic [63:0] want_v);
    mismatch_count = mismatch_count + 1;
    $display("[%0t] result %0d: %s is %h, want %h", $time, result_index, what, got_v, want_v);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      expected_results.delete();
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got_result = time_result_t'(m_axis_tdata[OUT_BITS-1:0]);
        if (expected_results.size() == 0) begin
          report_mismatch("transaction with nothing expected", 64'(got_result.sec), 64'd0);
        end else begin
          want_result = expected_results.pop_front();
          if (got_result.sec !== want_result.sec)
            report_mismatch("r_sec", 64'(got_result.sec), 64'(want_result.sec));
          if (got_result.usec !== want_result.usec)
            report_mismatch("r_usec", 64'(got_result.usec), 64'(want_result.usec));
          if (got_result.msec !== want_result.msec)
            report_mismatch("msec_out", 64'(got_result.msec), 64'(want_result.msec));
          if (got_result.order !== want_result.order)
            report_mismatch("order", 64'(got_result.order), 64'(want_result.order));
        end
        result_index = result_index + 1;
      end
      if (s_axis_tvalid && s_axis_tready)
        expected_results.push_back(predict_time_result(s_axis_tuser, s_axis_tdata));
    end
    pending_results <= expected_results.size();
  end

endmodule

@@ tb/sv/tb_top.sv @@
// Testbench top for the timestamp arithmetic unit: clock, reset, stimulus, flow control and verdict.
`timescale 1ns / 1ps

module tb_top;

  import stu_pkg::*;

  localparam int SEC_W          = SEC_WIDTH_DEF;
  localparam int IN_BITS        = 2 * SEC_W + 2 * USEC_W + MS_W;
  localparam int IN_W           = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_BITS       = SEC_W + USEC_W + MS_W + ORDER_W;
  localparam int OUT_W          = ((OUT_BITS + 7) / 8) * 8;
  localparam int RANDOM_ITEMS   = 1100;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 24;

  localparam op_t OP_FIRST_UNUSED = op_t'(OP_SUB_SECS + 1);
  localparam op_t OP_LAST         = '1;

  localparam logic [SEC_W-1:0] SEC_MAX = {1'b0, {(SEC_W-1){1'b1}}};
  localparam logic [SEC_W-1:0] SEC_MIN = {1'b1, {(SEC_W-1){1'b0}}};
  localparam logic [MS_W-1:0]  MS_MAX  = {1'b0, {(MS_W-1){1'b1}}};
  localparam logic [MS_W-1:0]  MS_MIN  = {1'b1, {(MS_W-1){1'b0}}};
  localparam int               USEC_TOP = USEC_PER_SEC - 1;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [IN_W-1:0]   s_axis_tdata = '0;
  op_t               s_axis_tuser = OP_ADD;
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [OUT_W-1:0]  m_axis_tdata;

  int mismatch_count;
  int pending_results;

  sec_usec_time_arith_unit dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  stu_result_checker #(
    .IN_W  (IN_W),
    .OUT_W (OUT_W)
  ) checker_i (
    .clk             (clk),
    .rst             (rst),
    .s_axis_tvalid   (s_axis_tvalid),
    .s_axis_tready   (s_axis_tready),
    .s_axis_tdata    (s_axis_tdata),
    .s_axis_tuser    (s_axis_tuser),
    .m_axis_tvalid   (m_axis_tvalid),
    .m_axis_tready   (m_axis_tready),
    .m_axis_tdata    (m_axis_tdata),
    .mismatch_count  (mismatch_count),
    .pending_results (pending_results)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Receiver flow control: the pattern changes at random, from
  // always ready through random and periodic stalls.
  int ready_mode   = 0;
  int ready_count  = 0;
  int stall_period = 4;
  int stall_len    = 1;

  always @(posedge clk) begin : rx_pattern
    int p;
    if (ready_count == 0) begin
      p = $urandom_range(2, 13);
      ready_mode   <= $urandom_range(0, 3);
      ready_count  <= $urandom_range(50, 300);
      stall_period <= p;
      stall_len    <= $urandom_range(1, p - 1);
    end else begin
      ready_count <= ready_count - 1;
    end
    case (ready_mode)
      0: m_axis_tready <= 1'b1;
      1: m_axis_tready <= 1'($urandom_range(0, 1));
      2: m_axis_tready <= (ready_count % stall_period) >= stall_len;
      default: m_axis_tready <= ($urandom_range(0, 29) != 0);
    endcase
  end

  int idle_cycles = 0;

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic logic [SEC_W-1:0] to_sec_bits(longint v);
    return v[SEC_W-1:0];
  endfunction

  function automatic logic [USEC_W-1:0] to_usec_bits(int v);
    return v[USEC_W-1:0];
  endfunction

  task automatic drive_item(input op_t op, input logic [SEC_W-1:0] as_v,
                            input logic [USEC_W-1:0] au_v, input logic [SEC_W-1:0] bs_v,
                            input logic [USEC_W-1:0] bu_v, input logic [MS_W-1:0] ms_v);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {{(IN_W-IN_BITS){1'b0}}, ms_v, bu_v, bs_v, au_v, as_v};
    do @(posedge clk); while (!s_axis_tready);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (pending_results != 0);
  endtask

  function automatic logic [SEC_W-1:0] rand_seconds();
    logic [63:0]      r;
    logic [SEC_W-1:0] v;
    r = {$urandom, $urandom};
    case ($urandom_range(0, 5))
      0: begin
        v = SEC_W'($urandom_range(0, 8));
        v = v - 4;
      end
      1: v = SEC_MAX - $urandom_range(0, 3);
      2: v = SEC_MIN + $urandom_range(0, 3);
      default: v = r[SEC_W-1:0];
    endcase
    return v;
  endfunction

  function automatic int rand_usec_mag();
    case ($urandom_range(0, 6))
      0: return 0;
      1: return 1;
      2: return USEC_TOP;
      3: return USEC_TOP - 1;
      4: return USEC_PER_SEC / 2;
      default: return $urandom_range(0, USEC_TOP);
    endcase
  endfunction

  function automatic logic [MS_W-1:0] rand_milliseconds();
    logic [63:0]     r;
    logic [MS_W-1:0] v;
    r = {$urandom, $urandom};
    case ($urandom_range(0, 4))
      0: begin
        v = MS_W'($urandom_range(0, 20000));
        v = v - 10000;
      end
      1: v = MS_MAX - $urandom_range(0, 2000);
      2: v = MS_MIN + $urandom_range(0, 2000);
      default: v = r[MS_W-1:0];
    endcase
    return v;
  endfunction

  // Mostly normalized operands (microseconds share the sign of the seconds);
  // now and then the sign is left to chance.
  task automatic make_operand(output logic [SEC_W-1:0] s, output logic [USEC_W-1:0] u);
    int  m;
    bit  neg;
    s = rand_seconds();
    m = rand_usec_mag();
    if ($urandom_range(0, 6) == 0 || s == '0) neg = 1'($urandom_range(0, 1));
    else neg = s[SEC_W-1];
    u = to_usec_bits(neg ? -m : m);
  endtask

  task automatic send_random_item();
    op_t               op;
    logic [SEC_W-1:0]  as_v, bs_v;
    logic [USEC_W-1:0] au_v, bu_v;
    int                pick;
    if ($urandom_range(0, 99) < 5) op = op_t'($urandom_range(OP_FIRST_UNUSED, OP_LAST));
    else op = op_t'($urandom_range(OP_ADD, OP_SUB_SECS));
    make_operand(as_v, au_v);
    make_operand(bs_v, bu_v);
    if (op == OP_CMP) begin
      pick = $urandom_range(0, 2);
      if (pick == 0) begin
        bs_v = as_v;
        bu_v = au_v;
      end else if (pick == 1) begin
        bs_v = as_v;
      end
    end
    drive_item(op, as_v, au_v, bs_v, bu_v, rand_milliseconds());
  endtask

  initial begin : stimulus
    int burst_left;
    int gap;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed corners: carries across the second boundary, wrapping seconds,
    // sign correction, compare outcomes, conversion extremes, unknown opcodes.
    drive_item(OP_ADD, SEC_MAX, to_usec_bits(USEC_TOP), to_sec_bits(1), to_usec_bits(1), '0);
    drive_item(OP_ADD, SEC_MIN, to_usec_bits(-USEC_TOP), SEC_MIN, to_usec_bits(-USEC_TOP),
               MS_MAX);
    drive_item(OP_ADD, to_sec_bits(5), to_usec_bits(500000), to_sec_bits(-3),
               to_usec_bits(-700000), '0);
    drive_item(OP_SUB, '0, '0, '0, to_usec_bits(1), '0);
    drive_item(OP_SUB, SEC_MIN, '0, to_sec_bits(1), '0, '0);
    drive_item(OP_SUB, SEC_MAX, to_usec_bits(USEC_TOP), SEC_MIN, to_usec_bits(-USEC_TOP),
               '1);
    drive_item(OP_INC, to_sec_bits(1), to_usec_bits(USEC_TOP), '0, '0, '0);
    drive_item(OP_INC, to_sec_bits(-1), to_usec_bits(-USEC_TOP), '0, '0, '0);
    drive_item(OP_INC, SEC_MAX, to_usec_bits(USEC_TOP), SEC_MAX, to_usec_bits(USEC_TOP), '0);
    drive_item(OP_DEC, '0, '0, '0, '0, '0);
    drive_item(OP_DEC, to_sec_bits(1), '0, '0, '0, '0);
    drive_item(OP_DEC, SEC_MIN, to_usec_bits(-USEC_TOP), '0, '0, '0);
    drive_item(OP_CMP, to_sec_bits(-7), to_usec_bits(-5), to_sec_bits(-7), to_usec_bits(-5),
               '0);
    drive_item(OP_CMP, to_sec_bits(3), to_usec_bits(10), to_sec_bits(3), to_usec_bits(11), '0);
    drive_item(OP_CMP, SEC_MAX, '0, SEC_MIN, to_usec_bits(USEC_TOP), '0);
    drive_item(OP_TO_MS, SEC_MAX, to_usec_bits(USEC_TOP), '0, '0, '0);
    drive_item(OP_TO_MS, SEC_MIN, to_usec_bits(-USEC_TOP), '0, '0, '0);
    drive_item(OP_TO_MS, '0, to_usec_bits(-999), '0, '0, '0);
    drive_item(OP_FROM_MS, SEC_MAX, to_usec_bits(USEC_TOP), '0, '0, MS_MAX);
    drive_item(OP_FROM_MS, '0, '0, '0, '0, MS_MIN);
    drive_item(OP_FROM_MS, '0, '0, '0, '0, '1);
    drive_item(OP_ADD_SECS, SEC_MAX, to_usec_bits(-123), to_sec_bits(1), '0, '0);
    drive_item(OP_SUB_SECS, SEC_MIN, to_usec_bits(USEC_TOP), to_sec_bits(1), '1, '0);
    drive_item(OP_FIRST_UNUSED, SEC_MAX, to_usec_bits(USEC_TOP), SEC_MIN, '1, MS_MAX);
    drive_item(OP_LAST, '1, '1, '1, '1, '1);
    wait_drained();

    burst_left = $urandom_range(1, 16);
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == RANDOM_ITEMS / 2) wait_drained();
      send_random_item();
      burst_left = burst_left - 1;
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 16);
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        if (gap != 0) begin
          s_axis_tvalid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
